@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the depthwise convolution core.
// Included by modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every rising edge outside reset.
`define DCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// The expression must never be true at a rising edge outside reset.
`define DCS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define DCS_ASSERT(lbl, clk, rstn, prop)
`define DCS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ src/dcs_pkg.sv @@
// Shared types and constants of the depthwise causal convolution core.
// No dependencies; imported by every module of the block.
`default_nettype none
package dcs_pkg;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_HIST   = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    // One classified command as it travels from the front to the back end.
    typedef struct packed {
        op_t                op;
        logic [9:0]         channel;
        logic [1:0]         tap;
        logic signed [15:0] value;
    } cmd_t;

    localparam int SAMPLE_W = 16;
    localparam int X_W      = 34;   // Q10.24 saturated sum
    localparam int SIG_W    = 17;   // Q1.16 sigmoid, 0 .. 1.0
    localparam int FRAC_W   = 28;   // u in Q24 over [0,16)
    localparam int ACT_W    = 23;

endpackage
`default_nettype wire

@@ src/dcs_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on dcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dcs_queue
    import dcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_pop,
    output cmd_t      rd_data
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DCS_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3)
    `DCS_ASSERT(a_ptr_gap, clk, rst_n, (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
    `DCS_ASSERT(a_push_counts, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))

endmodule
`default_nettype wire

@@ src/dcs_front.sv @@
// Front end: accepts input items, drops the ones that do nothing and
// queues the rest as commands. Depends on dcs_pkg.
`default_nettype none
module dcs_front
    import dcs_pkg::*;
#(
    parameter int CHANNELS = 1024,
    parameter int TAPS     = 4
)
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        clearing,
    input  wire logic        q_ready,
    output logic             q_valid,
    output cmd_t             q_data
);

    logic legal;

    always_comb
    begin
        q_data.op      = op_t'(s_tuser);
        q_data.channel = s_tdata[9:0];
        q_data.tap     = s_tdata[11:10];
        q_data.value   = s_tdata[27:12];
    end

    always_comb
    begin
        legal = 1'b0;
        if (32'(q_data.channel) < CHANNELS)
        begin
            priority if (s_tuser == OP_WEIGHT)
            begin
                legal = 32'(q_data.tap) < TAPS;
            end
            else if (s_tuser == OP_HIST)
            begin
                legal = 32'(q_data.tap) < TAPS - 1;
            end
            else if (s_tuser == OP_SAMPLE)
            begin
                legal = 1'b1;
            end
            else
            begin
                legal = 1'b0;
            end
        end
    end

    // Items that do nothing are taken and dropped here.
    assign s_tready = q_ready && !clearing;
    assign q_valid  = s_tvalid && !clearing && legal;

endmodule
`default_nettype wire

@@ src/dcs_back.sv @@
// Back end: weight and history memories, multiply-accumulate over the
// taps, piecewise-linear sigmoid and the output register. Depends on dcs_pkg.
`default_nettype none
`include "assert_macros.svh"
module dcs_back
    import dcs_pkg::*;
#(
    parameter int CHANNELS         = 1024,
    parameter int TAPS             = 4,
    parameter int SIGMOID_SEGMENTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_data,
    output logic             q_pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WAW   = $clog2(CHANNELS * TAPS);
    localparam int TW    = $clog2(TAPS);
    localparam int HROW  = (TAPS - 1) * SAMPLE_W;
    localparam int ACC_W = 32 + $clog2(TAPS);
    localparam int RW    = $clog2(SIGMOID_SEGMENTS + 1);
    localparam int PW    = FRAC_W + RW;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_READ = 11'b000_0000_0100,
        S_HWR  = 11'b000_0000_1000,
        S_MAC  = 11'b000_0001_0000,
        S_ACC  = 11'b000_0010_0000,
        S_SIG1 = 11'b000_0100_0000,
        S_SIG2 = 11'b000_1000_0000,
        S_SIG3 = 11'b001_0000_0000,
        S_MUL  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    // Shift-and-subtract division, only ever evaluated while building the table.
    function automatic longint unsigned udiv64(input longint unsigned num_in,
                                               input longint unsigned den_in);
        longint unsigned quo;
        logic [64:0]     rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num_in[b]};
            if (rem >= {1'b0, den_in})
            begin
                rem    = rem - {1'b0, den_in};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid breakpoint, worked out at elaboration with 64-bit integers.
    function automatic logic [SIG_W-1:0] rom_point(input int k);
        longint          num;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        num  = 16 * longint'(k) - 8 * longint'(SIGMOID_SEGMENTS);
        mag  = (num < 0) ? longint'(-num) : longint'(num);
        y    = udiv64(mag << 30, 64'(16 * SIGMOID_SEGMENTS));
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int n = 1; n <= 16; n++)
        begin
            term = udiv64((term * y) >> 30, 64'(n));
            if ((n & 1) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        e = longint'(sum);
        for (int i = 0; i < 4; i++)
        begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        den = (64'd1 << 30) + e;
        s   = udiv64((64'd1 << 46) + (den >> 1), den);
        if (num < 0)
        begin
            s = 64'd65536 - s;
        end
        return s[SIG_W-1:0];
    endfunction

    logic [SIG_W-1:0] sig_rom [SIGMOID_SEGMENTS + 1];

    for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++)
    begin : g_rom
        localparam logic [SIG_W-1:0] POINT = rom_point(k);
        assign sig_rom[k] = POINT;
    end

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg;
    logic [CH_AW-1:0]          ch_idx_reg;
    logic [WAW-1:0]            base_reg;
    logic [CH_AW-1:0]          clr_cnt_reg;
    logic [TW-1:0]             tap_cnt_reg;
    logic signed [31:0]        prod_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [X_W-1:0]     x_reg;
    logic                      neg_clamp_reg;
    logic                      pos_clamp_reg;
    logic [RW-1:0]             idx_reg;
    logic [FRAC_W-1:0]         pos_reg;
    logic [SIG_W-1:0]          lo_reg;
    logic [SIG_W+FRAC_W-1:0]   interp_reg;
    logic [SIG_W-1:0]          sig_reg;
    logic signed [X_W+SIG_W-1:0] p_reg;
    logic                      out_valid_reg;
    logic [9:0]                out_ch_reg;
    logic [ACT_W-1:0]          out_act_reg;

    logic [HROW-1:0]           hist_mem [CHANNELS];
    logic [HROW-1:0]           hist_rd_reg;
    logic signed [15:0]        w_mem [CHANNELS * TAPS];
    logic signed [15:0]        w_rd_reg;

    logic [CH_AW+9:0]          ch_ext;
    logic [WAW-1:0]            w_addr;
    logic                      w_we;
    logic                      hist_we;
    logic [CH_AW-1:0]          hist_waddr;
    logic [HROW-1:0]           hist_wdata;
    logic [HROW-1:0]           shift_row;
    logic [HROW-1:0]           patch_row;
    logic signed [15:0]        opnd [TAPS];
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [35:0]        acc_wide;
    logic signed [X_W-1:0]     x_sat;
    logic [FRAC_W-1:0]         u;
    logic [PW-1:0]             seg_prod;
    logic [SIG_W-1:0]          hi_pt;
    logic [SIG_W-1:0]          lo_pt;
    logic [SIG_W-1:0]          diff;
    logic signed [X_W+SIG_W:0] rnd;
    logic signed [23:0]        y;
    logic [ACT_W-1:0]          y_sat;
    logic                      out_free;

    assign ch_ext   = {{CH_AW{1'b0}}, q_data.channel};
    assign clearing = (state_reg == S_CLR);
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || m_tready;

    // Operands of the taps: stored samples oldest first, then the new one.
    for (genvar i = 0; i < TAPS - 1; i++)
    begin : g_opnd
        assign opnd[i] = hist_rd_reg[i*SAMPLE_W +: SAMPLE_W];
    end
    assign opnd[TAPS-1] = cmd_reg.value;

    always_comb
    begin
        for (int i = 0; i < TAPS - 2; i++)
        begin
            shift_row[i*SAMPLE_W +: SAMPLE_W] = hist_rd_reg[(i+1)*SAMPLE_W +: SAMPLE_W];
        end
        shift_row[(TAPS-2)*SAMPLE_W +: SAMPLE_W] = cmd_reg.value;
        for (int i = 0; i < TAPS - 1; i++)
        begin
            if (32'(cmd_reg.tap) == i)
            begin
                patch_row[i*SAMPLE_W +: SAMPLE_W] = cmd_reg.value;
            end
            else
            begin
                patch_row[i*SAMPLE_W +: SAMPLE_W] = hist_rd_reg[i*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    always_comb
    begin
        // The read address runs one tap ahead of the multiplier.
        if (state_reg == S_MAC && 32'(tap_cnt_reg) < TAPS - 1)
        begin
            w_addr = base_reg + WAW'(tap_cnt_reg) + WAW'(1);
        end
        else if (state_reg == S_READ && cmd_reg.op == OP_WEIGHT)
        begin
            w_addr = base_reg + WAW'(cmd_reg.tap);
        end
        else
        begin
            w_addr = base_reg;
        end
        w_we       = (state_reg == S_READ) && (cmd_reg.op == OP_WEIGHT);
        hist_we    = 1'b0;
        hist_waddr = ch_idx_reg;
        hist_wdata = shift_row;
        priority if (state_reg == S_CLR)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_cnt_reg;
            hist_wdata = '0;
        end
        else if (state_reg == S_HWR)
        begin
            hist_we    = 1'b1;
            hist_wdata = patch_row;
        end
        else if (state_reg == S_ACC)
        begin
            hist_we = 1'b1;
        end
        else
        begin
            hist_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[ch_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_addr] <= cmd_reg.value;
        end
        w_rd_reg <= w_mem[w_addr];
    end

    always_comb
    begin
        acc_sum  = acc_reg + {{(ACC_W-32){prod_reg[31]}}, prod_reg};
        acc_wide = 36'(acc_sum);
        priority if (acc_wide > 36'sd8589934591)
        begin
            x_sat = {1'b0, {(X_W-1){1'b1}}};
        end
        else if (acc_wide < -36'sd8589934592)
        begin
            x_sat = {1'b1, {(X_W-1){1'b0}}};
        end
        else
        begin
            x_sat = acc_wide[X_W-1:0];
        end
        u        = {~x_reg[FRAC_W-1], x_reg[FRAC_W-2:0]};
        seg_prod = PW'(u) * PW'(SIGMOID_SEGMENTS);
        lo_pt    = sig_rom[idx_reg];
        hi_pt    = sig_rom[idx_reg + RW'(1)];
        diff     = (hi_pt < lo_pt) ? '0 : hi_pt - lo_pt;
        rnd      = {p_reg[X_W+SIG_W-1], p_reg} + (X_W+SIG_W+1)'(64'd1 << 27);
        y        = rnd[X_W+SIG_W:28];
        priority if (y > 24'sd4194303)
        begin
            y_sat = {1'b0, {(ACT_W-1){1'b1}}};
        end
        else if (y < -24'sd4194304)
        begin
            y_sat = {1'b1, {(ACT_W-1){1'b0}}};
        end
        else
        begin
            y_sat = y[ACT_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == CH_AW'(CHANNELS - 1)) state_next = S_IDLE;
            S_IDLE: if (q_valid) state_next = S_READ;
            S_READ:
            begin
                unique case (cmd_reg.op)
                    OP_WEIGHT: state_next = S_IDLE;
                    OP_HIST:   state_next = S_HWR;
                    default:   state_next = S_MAC;
                endcase
            end
            S_HWR:  state_next = S_IDLE;
            S_MAC:  if (32'(tap_cnt_reg) == TAPS - 1) state_next = S_ACC;
            S_ACC:  state_next = S_SIG1;
            S_SIG1: state_next = S_SIG2;
            S_SIG2: state_next = S_SIG3;
            S_SIG3: state_next = S_MUL;
            S_MUL:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg    <= q_data;
            ch_idx_reg <= ch_ext[CH_AW-1:0];
            base_reg   <= WAW'(ch_ext[CH_AW-1:0] * TAPS);
        end
        if (state_reg == S_READ)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == S_MAC)
        begin
            acc_reg <= prod_vld_reg ? acc_sum : acc_reg;
        end
        if (state_reg == S_MAC)
        begin
            prod_reg <= w_rd_reg * opnd[tap_cnt_reg];
        end
        if (state_reg == S_ACC)
        begin
            x_reg <= x_sat;
        end
        if (state_reg == S_SIG1)
        begin
            neg_clamp_reg <= (x_reg < -34'sd134217728);
            pos_clamp_reg <= (x_reg >= 34'sd134217728);
            idx_reg       <= seg_prod[PW-1:FRAC_W];
            pos_reg       <= seg_prod[FRAC_W-1:0];
        end
        if (state_reg == S_SIG2)
        begin
            lo_reg     <= lo_pt;
            interp_reg <= (SIG_W+FRAC_W)'(diff) * (SIG_W+FRAC_W)'(pos_reg);
        end
        if (state_reg == S_SIG3)
        begin
            priority if (neg_clamp_reg)
            begin
                sig_reg <= '0;
            end
            else if (pos_clamp_reg)
            begin
                sig_reg <= SIG_W'(65536);
            end
            else
            begin
                sig_reg <= lo_reg + interp_reg[SIG_W+FRAC_W-1:FRAC_W];
            end
        end
        if (state_reg == S_MUL)
        begin
            p_reg <= x_reg * $signed({1'b0, sig_reg});
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_ch_reg  <= cmd_reg.channel;
            out_act_reg <= y_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            tap_cnt_reg   <= '0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CH_AW'(1);
            end
            if (state_reg == S_MAC)
            begin
                tap_cnt_reg  <= tap_cnt_reg + TW'(1);
                prod_vld_reg <= 1'b1;
            end
            else
            begin
                tap_cnt_reg  <= '0;
                prod_vld_reg <= 1'b0;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_act_reg, out_ch_reg};

    `DCS_NEVER(a_pop_idle_only, clk, rst_n, q_pop && state_reg != S_IDLE)
    `DCS_ASSERT(a_mac_to_acc, clk, rst_n,
        (state_reg == S_MAC && 32'(tap_cnt_reg) == TAPS - 1) |=> (state_reg == S_ACC))
    `DCS_ASSERT(a_clear_exit, clk, rst_n,
        (state_reg == S_CLR) |=> (state_reg == S_CLR || state_reg == S_IDLE))
    `DCS_NEVER(a_no_clobber, clk, rst_n,
        out_valid_reg && !m_tready && $past(state_reg) == S_OUT && state_reg == S_IDLE
        && !$past(out_free))

endmodule
`default_nettype wire

@@ src/depthwise_causal_conv_silu_core.sv @@
// Top level of the depthwise causal convolution with SiLU.
// Joins dcs_front, dcs_queue and dcs_back; depends on dcs_pkg.
//
//   channel  | direction | tdata (low bit up)              | tuser
//   s_axis   | in        | channel, tap, value, zero pad   | opcode
//   m_axis   | out       | out_channel, activation, pad    | -
//
// A sample item passes the back end as one memory read, one multiply per tap
// through the shared multiplier, then sigmoid and product. Weight items are
// written in the read state, history items in a separate write state; the
// queue holds two items. After reset a clearing pass over all CHANNELS entries
// zeroes the history memory; no item is taken until it ends. A stalled output
// holds the back end in its last state, and the input stalls on a full queue.
`default_nettype none
module depthwise_causal_conv_silu_core
    import dcs_pkg::*;
#(
    parameter int CHANNELS         = 1024,
    parameter int TAPS             = 4,
    parameter int SIGMOID_SEGMENTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // channel[9:0], tap[11:10], value[27:12]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // out_channel[9:0], activation[32:10]
);

    logic clearing;
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;
    logic bq_valid;
    logic bq_pop;
    cmd_t bq_data;

    dcs_front #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_ready  (fq_ready),
        .q_valid  (fq_valid),
        .q_data   (fq_data)
    );

    dcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_pop   (bq_pop),
        .rd_data  (bq_data)
    );

    dcs_back #(
        .CHANNELS         (CHANNELS),
        .TAPS             (TAPS),
        .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (bq_valid),
        .q_data   (bq_data),
        .q_pop    (bq_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

@@ tb/depthwise_causal_conv_silu_core_test.sv @@
// Self-checking testbench for depthwise_causal_conv_silu_core: weight and history loads,
// sample items checked against an in-bench convolution and SiLU predictor.
// Depends on dcs_pkg and the core RTL only.
`timescale 1ns / 100ps
`default_nettype none
module depthwise_causal_conv_silu_core_test;
    import dcs_pkg::*;

    localparam int NUM_CH    = 1024;
    localparam int NUM_TAPS  = 4;
    localparam int HIST_LEN  = NUM_TAPS - 1;
    localparam int SEGS      = 64;
    localparam int RAND_ITEMS = 1130;
    localparam int CYCLE_LIMIT = 400000;
    localparam op_t OP_UNUSED = op_t'(2'd3);

    typedef struct {
        logic [9:0]         channel;
        logic signed [22:0] activation;
    } act_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // Predictor state.
    logic signed [15:0] weight_mem [NUM_CH][NUM_TAPS];
    bit                 weight_set [NUM_CH][NUM_TAPS];
    logic signed [15:0] hist_mem   [NUM_CH][HIST_LEN];
    longint unsigned    sig_rom    [SEGS+1];
    int                 ready_chans[$];
    act_t               expected_acts[$];

    int error_count;
    int items_sent;
    int samples_sent;
    int acts_checked;
    int clamp_low_seen;
    int clamp_high_seen;
    int burst_left;
    int cycle_count;

    depthwise_causal_conv_silu_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned sig_point(int k);
        longint          num;
        longint unsigned mag, y, term, e, den, s;
        longint          sum;
        num = 16 * k - 8 * SEGS;
        mag = (num < 0) ? -num : num;
        y = (mag << 30) / (16 * SEGS);
        term = 64'd1 << 30;
        sum = longint'(64'd1 << 30);
        for (int n = 1; n <= 16; n++)
        begin
            term = ((term * y) >> 30) / n;
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        e = sum;
        for (int i = 0; i < 4; i++)
            e = (e * e + (64'd1 << 29)) >> 30;
        den = (64'd1 << 30) + e;
        s = ((64'd1 << 46) + den / 2) / den;
        if (num < 0)
            s = 65536 - s;
        return s;
    endfunction

    function automatic longint unsigned sigmoid_q16(longint x);
        longint unsigned u, prod, idx, pos, lo, hi;
        if (x < -(64'sd8 << 24))
            return 0;
        if (x >= (64'sd8 << 24))
            return 65536;
        u = x + (64'sd8 << 24);
        prod = u * SEGS;
        idx = prod >> 28;
        if (idx >= SEGS)
            idx = SEGS - 1;
        pos = prod - (idx << 28);
        lo = sig_rom[idx];
        hi = sig_rom[idx+1];
        if (hi < lo)
            return lo;
        return lo + (((hi - lo) * pos) >> 28);
    endfunction

    // Applies one accepted item to the predictor state and queues any activation.
    task automatic predict_item(op_t op, logic [9:0] ch, logic [1:0] tap, logic signed [15:0] val);
        longint acc, p, y;
        longint unsigned sig;
        act_t a;
        acc = 0;
        if (op == OP_WEIGHT)
        begin
            weight_mem[ch][tap] = val;
            if (!(weight_set[ch][0] && weight_set[ch][1] && weight_set[ch][2]
                  && weight_set[ch][3]))
            begin
                weight_set[ch][tap] = 1'b1;
                if (weight_set[ch][0] && weight_set[ch][1] && weight_set[ch][2]
                    && weight_set[ch][3])
                    ready_chans.push_back(int'(ch));
            end
        end
        else if (op == OP_HIST)
        begin
            if (tap < HIST_LEN)
                hist_mem[ch][tap] = val;
        end
        else if (op == OP_SAMPLE)
        begin
            for (int i = 0; i < HIST_LEN; i++)
                acc += longint'(weight_mem[ch][i]) * longint'(hist_mem[ch][i]);
            acc += longint'(weight_mem[ch][NUM_TAPS-1]) * longint'(val);
            if (acc > (64'sd1 << 33) - 1)
                acc = (64'sd1 << 33) - 1;
            if (acc < -(64'sd1 << 33))
                acc = -(64'sd1 << 33);
            for (int i = 0; i + 1 < HIST_LEN; i++)
                hist_mem[ch][i] = hist_mem[ch][i+1];
            hist_mem[ch][HIST_LEN-1] = val;
            if (acc < -(64'sd8 << 24))
                clamp_low_seen++;
            if (acc >= (64'sd8 << 24))
                clamp_high_seen++;
            sig = sigmoid_q16(acc);
            p = acc * longint'(sig);
            y = ((p + (64'sd1 << 52) + (64'sd1 << 27)) >>> 28) - (64'sd1 << 24);
            if (y > 4194303)
                y = 4194303;
            if (y < -4194304)
                y = -4194304;
            a.channel = ch;
            a.activation = y[22:0];
            expected_acts.push_back(a);
            samples_sent++;
        end
    endtask

    task automatic send_item(op_t op, logic [9:0] ch, logic [1:0] tap, logic signed [15:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 12);
                default: gap = $urandom_range(0, 1);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, val, tap, ch};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(op, ch, tap, val);
        items_sent++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic load_weights(logic [9:0] ch, logic signed [15:0] w0, logic signed [15:0] w1,
                                logic signed [15:0] w2, logic signed [15:0] w3);
        send_item(OP_WEIGHT, ch, 2'd0, w0);
        send_item(OP_WEIGHT, ch, 2'd1, w1);
        send_item(OP_WEIGHT, ch, 2'd2, w2);
        send_item(OP_WEIGHT, ch, 2'd3, w3);
    endtask

    // Extreme weights and samples on the lowest and highest channels; drives the upper clamp.
    task automatic test_extremes();
        load_weights(10'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        load_weights(10'd1023, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_item(OP_SAMPLE, 10'd0, 2'd0, 16'sh7FFF);
        send_item(OP_SAMPLE, 10'd0, 2'd3, -16'sd32768);
        send_item(OP_SAMPLE, 10'd1023, 2'd1, -16'sd32768);
        send_item(OP_SAMPLE, 10'd1023, 2'd2, 16'sh7FFF);
        send_item(OP_SAMPLE, 10'd0, 2'd0, 16'sd0);
    endtask

    // Restores a saved history and checks it is used by the next sample.
    task automatic test_history_restore();
        send_item(OP_HIST, 10'd0, 2'd0, -16'sd32768);
        send_item(OP_HIST, 10'd0, 2'd1, 16'sh7FFF);
        send_item(OP_HIST, 10'd0, 2'd2, 16'sd4096);
        send_item(OP_SAMPLE, 10'd0, 2'd0, 16'sd1);
        send_item(OP_SAMPLE, 10'd1023, 2'd0, 16'sd0);
    endtask

    // Unused opcode and an out-of-range history slot must change nothing.
    task automatic test_ignored_items();
        send_item(OP_UNUSED, 10'd0, 2'd1, 16'sh1234);
        send_item(OP_HIST, 10'd0, 2'd3, 16'sh7FFF);
        send_item(OP_SAMPLE, 10'd0, 2'd3, -16'sd1);
    endtask

    task automatic test_random_traffic();
        int sel;
        int n;
        bit paused;
        logic [9:0] ch;
        n = 0;
        paused = 1'b0;
        while (n < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (!paused && n >= RAND_ITEMS / 2)
            begin
                // Hold off the sender until the core has delivered everything.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (expected_acts.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                burst_left = 0;
            end
            if (sel < 8 || ready_chans.size() < 4)
            begin
                ch = 10'($urandom_range(0, NUM_CH - 1));
                load_weights(ch, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                n += 4;
            end
            else if (sel < 14)
            begin
                ch = 10'(ready_chans[$urandom_range(0, ready_chans.size() - 1)]);
                send_item(OP_WEIGHT, ch, 2'($urandom_range(0, 3)), 16'($urandom));
                n++;
            end
            else if (sel < 26)
            begin
                ch = 10'(ready_chans[$urandom_range(0, ready_chans.size() - 1)]);
                send_item(OP_HIST, ch, 2'($urandom_range(0, 3)), 16'($urandom));
                n++;
            end
            else if (sel < 30)
            begin
                send_item(OP_UNUSED, 10'($urandom_range(0, NUM_CH - 1)),
                          2'($urandom_range(0, 3)), 16'($urandom));
                n++;
            end
            else
            begin
                ch = 10'(ready_chans[$urandom_range(0, ready_chans.size() - 1)]);
                // Small samples now and then give sums that can fall inside the sigmoid table.
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_SAMPLE, ch, 2'($urandom_range(0, 3)),
                              16'(int'($urandom_range(0, 4096)) - 2048));
                else
                    send_item(OP_SAMPLE, ch, 2'($urandom_range(0, 3)), 16'($urandom));
                n++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Result checker with its own stall pattern, which rotates through four modes.
    always @(posedge clk or negedge rst_n)
    begin
        int stall_mode;
        act_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_acts.size() == 0)
                begin
                    report_mismatch("unexpected item, channel", m_tdata[9:0], -1);
                end
                else
                begin
                    want = expected_acts.pop_front();
                    acts_checked++;
                    if (m_tdata[9:0] !== want.channel)
                        report_mismatch("out_channel", m_tdata[9:0], want.channel);
                    if (m_tdata[32:10] !== want.activation)
                        report_mismatch("activation", $signed(m_tdata[32:10]),
                                        want.activation);
                end
            end
            stall_mode = (cycle_count / 256) % 4;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cycle_count[4];
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        rst_n       <= 1'b0;
        burst_left  = 0;
        for (int k = 0; k <= SEGS; k++)
            sig_rom[k] = sig_point(k);
        for (int c = 0; c < NUM_CH; c++)
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                weight_mem[c][t] = '0;
                weight_set[c][t] = 1'b0;
                if (t < HIST_LEN)
                    hist_mem[c][t] = '0;
            end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_history_restore();
        test_ignored_items();
        test_random_traffic();

        while (expected_acts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d items, %0d samples; checked %0d activations", items_sent,
                 samples_sent, acts_checked);
        $display("Sigmoid clamp hits: %0d below range, %0d above range; %0d channels loaded",
                 clamp_low_seen, clamp_high_seen, ready_chans.size());
        if (error_count == 0 && expected_acts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/dcs_pkg.sv
src/dcs_queue.sv
src/dcs_front.sv
src/dcs_back.sv
src/depthwise_causal_conv_silu_core.sv
tb/depthwise_causal_conv_silu_core_test.sv
